### rtl/sgbr_pkg.sv
`timescale 1ns / 1ps

package sgbr_pkg;

    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 240;

    localparam int FONT_ROWS  = 7;
    localparam int FONT_COLS  = 5;
    localparam int GLYPH_BITS = FONT_ROWS * FONT_COLS;

    localparam int POS_W   = 13;
    localparam int CODE_W  = 8;
    localparam int COLOR_W = 16;
    localparam int SCALE_W = 6;
    localparam int RX_W    = 9;
    localparam int RY_W    = 8;
    localparam int SIZE_W  = 6;

    localparam int JOB_QUEUE_DEPTH  = 2;
    localparam int RECT_QUEUE_DEPTH = 2;

    // One decoded character on its way from the front end to the scanner.
    typedef struct packed {
        logic [GLYPH_BITS-1:0]   glyph;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [COLOR_W-1:0]      color;
        logic [SCALE_W-1:0]      scale;
    } t_job;

    typedef struct packed {
        logic [RX_W-1:0]    x;
        logic [RY_W-1:0]    y;
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_rect;

    // Row 0 sits in the top five bits, and within a row the leftmost column is
    // the most significant bit, so the scanner simply walks from bit 34 down.
    function automatic logic [GLYPH_BITS-1:0] glyph_lookup(input logic [CODE_W-1:0] code);
        logic [GLYPH_BITS-1:0] g;
        case (code)
            8'h30: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            8'h31: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            8'h32: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            8'h33: g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
            8'h34: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            8'h35: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
            8'h36: g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            8'h37: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            8'h38: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            8'h39: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
            8'h41: g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            8'h42: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
            8'h43: g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
            8'h44: g = {5'h1E, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1E};
            8'h45: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            8'h46: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            8'h47: g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
            8'h48: g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            8'h49: g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            8'h4B: g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            8'h4C: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            8'h4D: g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            8'h4E: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            8'h4F: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            8'h50: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            8'h52: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            8'h53: g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            8'h54: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            8'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            8'h57: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
            8'h59: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
            8'h2D: g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

### rtl/sgbr_fifo.sv
`timescale 1ns / 1ps

module sgbr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    // DEPTH must be a power of two so that the pointers wrap on their own.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (DEPTH > 1) ? AW'(r_wptr + 1'b1) : '0;
            end
            if (rd_en) begin
                r_rptr <= (DEPTH > 1) ? AW'(r_rptr + 1'b1) : '0;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/sgbr_front.sv
`timescale 1ns / 1ps

module sgbr_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic signed [sgbr_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [sgbr_pkg::POS_W-1:0]   i_pos_y,
    input  logic [sgbr_pkg::CODE_W-1:0]         i_char_code,
    input  logic [sgbr_pkg::COLOR_W-1:0]        i_pixel_color,
    input  logic [sgbr_pkg::SCALE_W-1:0]        i_scale_factor,
    output sgbr_pkg::t_job                      o_job,
    output logic                                o_job_empty,
    input  logic                                i_job_pop
);

    sgbr_pkg::t_job job;
    logic           job_push;

    always_comb begin
        job.glyph = sgbr_pkg::glyph_lookup(i_char_code);
        job.pos_x = i_pos_x;
        job.pos_y = i_pos_y;
        job.color = i_pixel_color;
        job.scale = (i_scale_factor == '0) ? sgbr_pkg::SCALE_W'(1) : i_scale_factor;
    end

    // Blank glyphs produce nothing, so they are accepted and dropped here.
    assign job_push = i_push && (job.glyph != '0);

    sgbr_fifo #(
        .WIDTH ($bits(sgbr_pkg::t_job)),
        .DEPTH (sgbr_pkg::JOB_QUEUE_DEPTH)
    ) u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job),
        .o_full  (o_full),
        .i_pop   (i_job_pop),
        .o_data  (o_job),
        .o_empty (o_job_empty)
    );

endmodule

### rtl/sgbr_back.sv
`timescale 1ns / 1ps

module sgbr_back #(
    parameter int SCREEN_WIDTH  = sgbr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = sgbr_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sgbr_pkg::t_job  i_job,
    input  logic            i_job_empty,
    output logic            o_job_pop,
    output sgbr_pkg::t_rect o_rect,
    output logic            o_rect_push,
    input  logic            i_rect_full
);

    localparam int CW = 16;
    localparam logic signed [CW-1:0] SCR_W = CW'(SCREEN_WIDTH);
    localparam logic signed [CW-1:0] SCR_H = CW'(SCREEN_HEIGHT);
    localparam logic [2:0] LAST_ROW = 3'(sgbr_pkg::FONT_ROWS - 1);
    localparam logic [2:0] LAST_COL = 3'(sgbr_pkg::FONT_COLS - 1);

    logic                              r_busy;
    logic [sgbr_pkg::GLYPH_BITS-1:0]   r_bits;
    logic [2:0]                        r_row;
    logic [2:0]                        r_col;
    logic signed [CW-1:0]              r_px;
    logic signed [CW-1:0]              r_bx;
    logic signed [CW-1:0]              r_by;
    logic [sgbr_pkg::SCALE_W-1:0]      r_s;
    logic [sgbr_pkg::COLOR_W-1:0]      r_color;

    logic                              r_pend_v;
    logic                              r_pend_fin;
    sgbr_pkg::t_rect                   r_pend;

    logic signed [CW-1:0] s_ext;
    logic signed [CW-1:0] bx1, bw1, bw2;
    logic signed [CW-1:0] by1, bh1, bh2;
    logic                 cur_vis;
    logic                 cur_end;
    logic                 cur_hit;
    logic                 push;
    logic                 go;
    logic                 load;
    sgbr_pkg::t_rect      new_rect;

    always_comb begin
        s_ext = signed'(CW'(r_s));

        bx1 = (r_bx < 0) ? '0 : r_bx;
        bw1 = (r_bx < 0) ? s_ext + r_bx : s_ext;
        by1 = (r_by < 0) ? '0 : r_by;
        bh1 = (r_by < 0) ? s_ext + r_by : s_ext;

        bw2 = (bx1 + bw1 > SCR_W) ? SCR_W - bx1 : bw1;
        bh2 = (by1 + bh1 > SCR_H) ? SCR_H - by1 : bh1;

        cur_vis = (bw2 > 0) && (bh2 > 0);

        new_rect.x     = bx1[sgbr_pkg::RX_W-1:0];
        new_rect.y     = by1[sgbr_pkg::RY_W-1:0];
        new_rect.w     = bw2[sgbr_pkg::SIZE_W-1:0];
        new_rect.h     = bh2[sgbr_pkg::SIZE_W-1:0];
        new_rect.color = r_color;
        new_rect.last  = 1'b0;
    end

    assign cur_end = (r_row == LAST_ROW) && (r_col == LAST_COL);
    assign cur_hit = r_busy && r_bits[sgbr_pkg::GLYPH_BITS-1] && cur_vis;

    // The newest visible block is held back one step: it can only be flagged
    // as the last one once the scan knows that no other visible block follows.
    assign push        = r_pend_v && (r_pend_fin || cur_hit);
    assign go          = !(push && i_rect_full);
    assign o_rect_push = push && go;
    assign load        = go && (!r_busy || cur_end) && !i_job_empty;
    assign o_job_pop   = load;

    always_comb begin
        o_rect      = r_pend;
        o_rect.last = r_pend_fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pend_v <= 1'b0;
        end else if (go) begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (cur_end) begin
                r_busy <= 1'b0;
            end

            if (cur_hit) begin
                r_pend_v <= 1'b1;
            end else if (push) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            if (cur_hit) begin
                r_pend     <= new_rect;
                r_pend_fin <= cur_end;
            end else if (r_busy && cur_end && r_pend_v) begin
                r_pend_fin <= 1'b1;
            end

            if (load) begin
                r_bits  <= i_job.glyph;
                r_row   <= '0;
                r_col   <= '0;
                r_px    <= CW'(i_job.pos_x);
                r_bx    <= CW'(i_job.pos_x);
                r_by    <= CW'(i_job.pos_y);
                r_s     <= i_job.scale;
                r_color <= i_job.color;
            end else if (r_busy) begin
                r_bits <= r_bits << 1;
                if (r_col == LAST_COL) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                    r_bx  <= r_px;
                    r_by  <= r_by + s_ext;
                end else begin
                    r_col <= r_col + 1'b1;
                    r_bx  <= r_bx + s_ext;
                end
            end
        end
    end

endmodule

### rtl/scaled_glyph_block_renderer.sv
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// ------    -------------------  ---------------------------------------------------
// input     push / full          i_pos_x, i_pos_y, i_char_code, i_pixel_color,
//                                i_scale_factor
// result    empty / pop          o_rect_x, o_rect_y, o_rect_w, o_rect_h,
//                                o_rect_color, o_last_block
//
// The cell scanner walks a character with a non-blank glyph one cell per cycle while the
// result queue does not freeze it; blank and unsupported codes are dropped in the front end.
// A two-entry job queue lets characters be taken while the scanner is busy. Each visible
// block waits for the next visible block or the end of the scan before it enters the result
// queue. Reset is synchronous and clears only pointers, counts and flags. A full result queue
// freezes the scanner only while a block waits for it; the front end stalls only on its queue.

module scaled_glyph_block_renderer #(
    parameter int SCREEN_WIDTH  = sgbr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = sgbr_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [sgbr_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [sgbr_pkg::POS_W-1:0]   i_pos_y,
    input  logic [sgbr_pkg::CODE_W-1:0]         i_char_code,
    input  logic [sgbr_pkg::COLOR_W-1:0]        i_pixel_color,
    input  logic [sgbr_pkg::SCALE_W-1:0]        i_scale_factor,
    output logic                                empty,
    input  logic                                pop,
    output logic [sgbr_pkg::RX_W-1:0]           o_rect_x,
    output logic [sgbr_pkg::RY_W-1:0]           o_rect_y,
    output logic [sgbr_pkg::SIZE_W-1:0]         o_rect_w,
    output logic [sgbr_pkg::SIZE_W-1:0]         o_rect_h,
    output logic [sgbr_pkg::COLOR_W-1:0]        o_rect_color,
    output logic                                o_last_block
);

    sgbr_pkg::t_job  job;
    logic            job_empty;
    logic            job_pop;
    sgbr_pkg::t_rect rect_in;
    sgbr_pkg::t_rect rect_out;
    logic            rect_push;
    logic            rect_full;

    sgbr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_char_code    (i_char_code),
        .i_pixel_color  (i_pixel_color),
        .i_scale_factor (i_scale_factor),
        .o_job          (job),
        .o_job_empty    (job_empty),
        .i_job_pop      (job_pop)
    );

    sgbr_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_rect      (rect_in),
        .o_rect_push (rect_push),
        .i_rect_full (rect_full)
    );

    sgbr_fifo #(
        .WIDTH ($bits(sgbr_pkg::t_rect)),
        .DEPTH (sgbr_pkg::RECT_QUEUE_DEPTH)
    ) u_rect_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rect_push),
        .i_data  (rect_in),
        .o_full  (rect_full),
        .i_pop   (pop),
        .o_data  (rect_out),
        .o_empty (empty)
    );

    assign o_rect_x     = rect_out.x;
    assign o_rect_y     = rect_out.y;
    assign o_rect_w     = rect_out.w;
    assign o_rect_h     = rect_out.h;
    assign o_rect_color = rect_out.color;
    assign o_last_block = rect_out.last;

endmodule

### test/tb_scaled_glyph_block_renderer.sv
`timescale 1ns / 1ps

module tb_scaled_glyph_block_renderer;

    localparam int RANDOM_CHARS  = 260;
    localparam int CALM_TAIL     = 30;
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 150;

    typedef logic [0:sgbr_pkg::FONT_ROWS-1][sgbr_pkg::FONT_COLS-1:0] t_glyph_rows;

    typedef struct {
        logic signed [sgbr_pkg::POS_W-1:0] pos_x;
        logic signed [sgbr_pkg::POS_W-1:0] pos_y;
        logic [sgbr_pkg::CODE_W-1:0]       code;
        logic [sgbr_pkg::COLOR_W-1:0]      color;
        logic [sgbr_pkg::SCALE_W-1:0]      scale;
        logic                              drain_first;
    } t_char_req;

    typedef struct {
        logic [sgbr_pkg::RX_W-1:0]    x;
        logic [sgbr_pkg::RY_W-1:0]    y;
        logic [sgbr_pkg::SIZE_W-1:0]  w;
        logic [sgbr_pkg::SIZE_W-1:0]  h;
        logic [sgbr_pkg::COLOR_W-1:0] color;
        logic                         last;
    } t_block;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              push = 1'b0;
    logic                              full;
    logic signed [sgbr_pkg::POS_W-1:0] i_pos_x = '0;
    logic signed [sgbr_pkg::POS_W-1:0] i_pos_y = '0;
    logic [sgbr_pkg::CODE_W-1:0]       i_char_code = '0;
    logic [sgbr_pkg::COLOR_W-1:0]      i_pixel_color = '0;
    logic [sgbr_pkg::SCALE_W-1:0]      i_scale_factor = '0;
    logic                              empty;
    logic                              pop = 1'b0;
    logic [sgbr_pkg::RX_W-1:0]         o_rect_x;
    logic [sgbr_pkg::RY_W-1:0]         o_rect_y;
    logic [sgbr_pkg::SIZE_W-1:0]       o_rect_w;
    logic [sgbr_pkg::SIZE_W-1:0]       o_rect_h;
    logic [sgbr_pkg::COLOR_W-1:0]      o_rect_color;
    logic                              o_last_block;

    t_char_req chars_to_send[$];
    t_char_req char_now;
    t_block    blocks_due[$];
    int        blocks_rendered = 0;
    int        blocks_seen = 0;
    int        n_errors = 0;
    int        stalled_cycles = 0;
    int        send_gap = 0;
    int        pop_gap = 0;
    logic      calm = 1'b0;

    string glyph_set = "0123456789ABCDEFGHIKLMNOPRSTUWY-";

    scaled_glyph_block_renderer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_char_code    (i_char_code),
        .i_pixel_color  (i_pixel_color),
        .i_scale_factor (i_scale_factor),
        .empty          (empty),
        .pop            (pop),
        .o_rect_x       (o_rect_x),
        .o_rect_y       (o_rect_y),
        .o_rect_w       (o_rect_w),
        .o_rect_h       (o_rect_h),
        .o_rect_color   (o_rect_color),
        .o_last_block   (o_last_block)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_glyph_rows font_glyph(input logic [sgbr_pkg::CODE_W-1:0] code);
        t_glyph_rows g;
        case (code)
            "0": g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            "1": g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            "2": g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            "3": g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
            "4": g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            "5": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
            "6": g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            "7": g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            "8": g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            "9": g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
            "A": g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "B": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
            "C": g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
            "D": g = {5'h1E, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1E};
            "E": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            "F": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            "G": g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
            "H": g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "I": g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            "K": g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            "L": g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            "M": g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            "N": g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            "O": g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "P": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            "R": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            "S": g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            "T": g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            "U": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "W": g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
            "Y": g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
            "-": g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
            default: g = '0;
        endcase
        return g;
    endfunction

    // Appends the clipped blocks of one character to blocks_due.
    function automatic void render_glyph(input t_char_req req);
        t_glyph_rows rows;
        int          px, py, s, bx, by, bw, bh;
        t_block      blk;
        t_block      drawn[$];
        rows = font_glyph(req.code);
        px   = int'(req.pos_x);
        py   = int'(req.pos_y);
        s    = (req.scale == 0) ? 1 : int'(req.scale);
        for (int row = 0; row < sgbr_pkg::FONT_ROWS; row++) begin
            for (int col = 0; col < sgbr_pkg::FONT_COLS; col++) begin
                if (rows[row][sgbr_pkg::FONT_COLS-1-col]) begin
                    bx = px + col * s;
                    by = py + row * s;
                    bw = s;
                    bh = s;
                    if (bx < 0) begin
                        bw = bw + bx;
                        bx = 0;
                    end
                    if (by < 0) begin
                        bh = bh + by;
                        by = 0;
                    end
                    if (bx + bw > sgbr_pkg::SCREEN_WIDTH_DEF) begin
                        bw = sgbr_pkg::SCREEN_WIDTH_DEF - bx;
                    end
                    if (by + bh > sgbr_pkg::SCREEN_HEIGHT_DEF) begin
                        bh = sgbr_pkg::SCREEN_HEIGHT_DEF - by;
                    end
                    if (bw > 0 && bh > 0) begin
                        blk.x     = bx[sgbr_pkg::RX_W-1:0];
                        blk.y     = by[sgbr_pkg::RY_W-1:0];
                        blk.w     = bw[sgbr_pkg::SIZE_W-1:0];
                        blk.h     = bh[sgbr_pkg::SIZE_W-1:0];
                        blk.color = req.color;
                        blk.last  = 1'b0;
                        drawn.push_back(blk);
                    end
                end
            end
        end
        if (drawn.size() > 0) begin
            drawn[drawn.size()-1].last = 1'b1;
        end
        foreach (drawn[i]) begin
            blocks_due.push_back(drawn[i]);
        end
        blocks_rendered += drawn.size();
    endfunction

    task automatic add_char(input int x, input int y, input logic [sgbr_pkg::CODE_W-1:0] code,
                            input logic [sgbr_pkg::COLOR_W-1:0] color, input int scale,
                            input logic drain_first);
        t_char_req req;
        req.pos_x       = sgbr_pkg::POS_W'(x);
        req.pos_y       = sgbr_pkg::POS_W'(y);
        req.code        = code;
        req.color       = color;
        req.scale       = sgbr_pkg::SCALE_W'(scale);
        req.drain_first = drain_first;
        chars_to_send.push_back(req);
    endtask

    task automatic add_random_char(input logic drain_first);
        int x, y, scale;
        logic [sgbr_pkg::CODE_W-1:0] code;
        if ($urandom_range(0, 9) == 0) begin
            x = int'($urandom);
            y = int'($urandom);
        end else begin
            x = int'($urandom_range(0, 420)) - 80;
            y = int'($urandom_range(0, 340)) - 80;
        end
        if ($urandom_range(0, 4) == 0) begin
            scale = $urandom_range(0, 63);
        end else begin
            scale = $urandom_range(0, 10);
        end
        if ($urandom_range(0, 9) == 0) begin
            code = sgbr_pkg::CODE_W'($urandom_range(0, 255));
        end else begin
            code = glyph_set[$urandom_range(0, glyph_set.len() - 1)];
        end
        add_char(x, y, code, sgbr_pkg::COLOR_W'($urandom), scale, drain_first);
    endtask

    // Driver: one character per push transaction, with random idle bursts.
    always @(posedge i_clk) begin : drive_chars
        logic push_next;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            push_next = push;
            if (push && !full) begin
                render_glyph(char_now);
                push_next = 1'b0;
            end
            if (!push_next) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (chars_to_send.size() > 0) begin
                    if (chars_to_send[0].drain_first && blocks_seen != blocks_rendered) begin
                        // Hold off until every block already promised has been popped.
                    end else if (!calm && $urandom_range(0, 5) == 0) begin
                        send_gap = $urandom_range(0, 14);
                    end else begin
                        char_now       = chars_to_send.pop_front();
                        i_pos_x        <= char_now.pos_x;
                        i_pos_y        <= char_now.pos_y;
                        i_char_code    <= char_now.code;
                        i_pixel_color  <= char_now.color;
                        i_scale_factor <= char_now.scale;
                        push_next      = 1'b1;
                    end
                end
            end
            push <= push_next;
            calm <= (chars_to_send.size() <= CALM_TAIL);
        end
    end

    // Monitor: checks each popped block against the oldest one still due.
    always @(posedge i_clk) begin : check_blocks
        t_block want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (blocks_due.size() == 0) begin
                    $error("unexpected block x=%0d y=%0d w=%0d h=%0d",
                           o_rect_x, o_rect_y, o_rect_w, o_rect_h);
                    n_errors++;
                end else begin
                    want = blocks_due.pop_front();
                    if (o_rect_x !== want.x) begin
                        $error("rect_x: expected %0d, actual %0d", want.x, o_rect_x);
                        n_errors++;
                    end
                    if (o_rect_y !== want.y) begin
                        $error("rect_y: expected %0d, actual %0d", want.y, o_rect_y);
                        n_errors++;
                    end
                    if (o_rect_w !== want.w) begin
                        $error("rect_w: expected %0d, actual %0d", want.w, o_rect_w);
                        n_errors++;
                    end
                    if (o_rect_h !== want.h) begin
                        $error("rect_h: expected %0d, actual %0d", want.h, o_rect_h);
                        n_errors++;
                    end
                    if (o_rect_color !== want.color) begin
                        $error("rect_color: expected %0h, actual %0h",
                               want.color, o_rect_color);
                        n_errors++;
                    end
                    if (o_last_block !== want.last) begin
                        $error("last_block: expected %0b, actual %0b",
                               want.last, o_last_block);
                        n_errors++;
                    end
                    blocks_seen <= blocks_seen + 1;
                end
            end
            if (calm) begin
                pop <= 1'b1;
            end else if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                pop_gap = $urandom_range(0, 14);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial begin
        wait (stalled_cycles >= STALL_LIMIT);
        $display("scaled_glyph_block_renderer regression: fail");
        $finish;
    end

    initial begin
        add_char(0, 0, "8", 16'hFFFF, 1, 1'b0);
        add_char(10, 10, "0", 16'h0000, 0, 1'b0);
        add_char(20, 20, " ", 16'h1234, 4, 1'b0);
        add_char(20, 20, 8'hFF, 16'h4321, 4, 1'b0);
        add_char(0, 0, 8'h00, 16'hFFFF, 1, 1'b0);
        add_char(50, 50, "J", 16'h0F0F, 2, 1'b0);
        add_char(100, 100, "-", 16'hF800, 3, 1'b0);
        add_char(-10, 30, "H", 16'h07E0, 4, 1'b0);
        add_char(30, -7, "M", 16'h001F, 3, 1'b0);
        add_char(300, 40, "W", 16'hFFE0, 8, 1'b0);
        add_char(40, 230, "E", 16'h07FF, 5, 1'b0);
        add_char(-4096, -4096, "8", 16'h1234, 63, 1'b0);
        add_char(4095, 4095, "8", 16'hEDCB, 63, 1'b0);
        add_char(-100, -100, "A", 16'h8001, 63, 1'b0);
        add_char(0, 0, "8", 16'hAAAA, 63, 1'b1);
        add_char(319, 239, "B", 16'h5555, 1, 1'b0);
        add_char(-1, -1, "Y", 16'h0001, 2, 1'b0);
        add_char(-4, -6, "4", 16'h8000, 1, 1'b0);
        add_char(160, 120, "T", 16'h5555, 63, 1'b0);
        add_char(-20, 100, "1", 16'hC3C3, 12, 1'b0);
        for (int i = 0; i < RANDOM_CHARS; i++) begin
            add_random_char(i == RANDOM_CHARS / 2);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (chars_to_send.size() == 0 && !push);
        wait (blocks_seen == blocks_rendered);
        // No further block may appear once every expected block has been popped.
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (n_errors == 0 && blocks_due.size() == 0) begin
            $display("scaled_glyph_block_renderer regression: pass");
        end else begin
            $display("scaled_glyph_block_renderer regression: fail");
        end
        $finish;
    end

endmodule
